>>> src/wheel_velocity_pd_drive_assert.svh
// assertion macros for the wheel velocity pd drive
// each check runs on the rising edge of clk and is idle while rst_n is low
`ifndef WHEEL_VELOCITY_PD_DRIVE_ASSERT_SVH
`define WHEEL_VELOCITY_PD_DRIVE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define WVPD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WVPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define WVPD_ASSERT_NOW(label, ante, cons, msg)
`define WVPD_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

>>> src/wvpd_pkg.sv
package wvpd_pkg;

    // field widths
    localparam int SPEED_BITS = 16;
    localparam int DRIVE_BITS = 8;
    localparam int GAIN_W     = 16;
    localparam int LIM_W      = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // serial multiplier datapath
    localparam int MAC_IN_W   = 19;
    localparam int MAC_OUT_W  = MAC_IN_W + GAIN_W;
    localparam int CNT_W      = $clog2(GAIN_W);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INV_RADIUS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_P     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_P    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_D_GAIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ANG    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DRIVE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND   = 3'd6;

    // control word for one shift-add multiplier
    typedef struct packed {
        logic clear;
        logic step;
        logic mult_bit;
    } mac_ctrl_t;

endpackage

>>> src/wheel_velocity_pd_drive.sv
// Incremental PD velocity drive for a left and a right wheel.
// Input channel (in_valid/in_ready): one word holds wheel_select, target_speed
// and measured_speed in signed Q8.8. Output channel (out_valid/out_ready): one
// word per input word with wheel_id, drive_magnitude, drive_direction and
// signed_drive. Config channel (cfg_valid/cfg_ready, always ready): cfg_index
// picks the register, cfg_data is the value; unknown indexes are dropped.
// Writes belong to idle periods only.
// One word is in flight at a time. Two shift-add multipliers scan 16 gain bits
// msb first, one bit per cycle: one pass scales both speeds by the inverse
// radius, a second pass forms the P and D products. An active word runs the
// error step, the second pass and the sum, rounding and accumulate steps
// before its result is loaded; a deadband word loads a zero result at the clamp
// step. The next word is taken in the cycle after the load.
// Reset restores register defaults, clears both accumulators and previous
// errors, and arms the derivative skip for both wheels.
// The result sits in an output register; a stalled receiver holds the block in
// its last step until the register frees, and nothing is lost or repeated.
`include "wheel_velocity_pd_drive_assert.svh"

module wheel_velocity_pd_drive (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic                                    wheel_select,
    input  logic signed [wvpd_pkg::SPEED_BITS-1:0]  target_speed,
    input  logic signed [wvpd_pkg::SPEED_BITS-1:0]  measured_speed,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic                                    wheel_id,
    output logic        [wvpd_pkg::DRIVE_BITS-1:0]  drive_magnitude,
    output logic                                    drive_direction,
    output logic signed [wvpd_pkg::DRIVE_BITS:0]    signed_drive,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic        [wvpd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic        [wvpd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import wvpd_pkg::*;

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL1  = 4'd1;
    localparam logic [3:0] S_SCALE = 4'd2;
    localparam logic [3:0] S_CLAMP = 4'd3;
    localparam logic [3:0] S_ERR   = 4'd4;
    localparam logic [3:0] S_MUL2  = 4'd5;
    localparam logic [3:0] S_SUM   = 4'd6;
    localparam logic [3:0] S_RND   = 4'd7;
    localparam logic [3:0] S_ACC   = 4'd8;

    // internal widths
    localparam int ANG_W  = 24;
    localparam int DES_W  = 16;
    localparam int CUR_W  = 17;
    localparam int ERR_W  = 18;
    localparam int DERR_W = ERR_W + 1;
    localparam int SUM_W  = MAC_OUT_W + 1;
    localparam int STEP_W = SUM_W - 16;
    localparam int NDR_W  = STEP_W + 1;
    localparam int ACC_W  = DRIVE_BITS + 1;

    localparam logic [MAC_OUT_W-1:0] ANG_HALF  = MAC_OUT_W'(128);
    localparam logic [MAC_OUT_W-1:0] ANG_HALFM = MAC_OUT_W'(127);
    localparam logic [SUM_W-1:0]     SUM_HALF  = SUM_W'(32768);
    localparam logic [SUM_W-1:0]     SUM_HALFM = SUM_W'(32767);

    // configuration registers
    logic [GAIN_W-1:0]     inv_radius_reg;
    logic [GAIN_W-1:0]     left_p_reg;
    logic [GAIN_W-1:0]     right_p_reg;
    logic [GAIN_W-1:0]     d_gain_reg;
    logic [LIM_W-1:0]      max_ang_reg;
    logic [DRIVE_BITS-1:0] max_drive_reg;
    logic [LIM_W-1:0]      deadband_reg;

    // per-wheel state
    logic signed [ERR_W-1:0] prev_err_reg [2];
    logic                    skip_reg     [2];
    logic signed [ACC_W-1:0] acc_reg      [2];

    // control
    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;
    logic             load_out;
    logic             commit;

    // working payload
    logic                     wheel_reg;
    logic signed [SPEED_BITS-1:0] tgt_reg, meas_reg;
    logic signed [ANG_W-1:0]  des_reg, des_next;
    logic signed [CUR_W-1:0]  cur_reg, cur_next;
    logic signed [DES_W-1:0]  desc_reg, desc_next;
    logic signed [ERR_W-1:0]  err_reg, err_next;
    logic signed [DERR_W-1:0] derr_reg, derr_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic signed [STEP_W-1:0] step_reg, step_next;

    // output payload
    logic                     wheel_id_reg, wheel_id_next;
    logic [DRIVE_BITS-1:0]    mag_reg, mag_next;
    logic                     dir_reg, dir_next;
    logic signed [ACC_W-1:0]  sdrive_reg, sdrive_next;

    // datapath intermediates
    mac_ctrl_t                   ctrl0, ctrl1;
    logic signed [MAC_IN_W-1:0]  op0, op1;
    logic signed [MAC_OUT_W-1:0] prod0, prod1;
    logic signed [MAC_OUT_W-1:0] tgt_rnd, meas_rnd;
    logic signed [ANG_W-1:0]     cur_ang;
    logic        [ANG_W-1:0]     des_mag;
    logic signed [ANG_W-1:0]     lim_s;
    logic                        in_deadband;
    logic signed [SUM_W-1:0]     sum_rnd;
    logic signed [NDR_W-1:0]     nd_raw;
    logic signed [NDR_W-1:0]     md_s;
    logic signed [ACC_W-1:0]     nd;
    logic [GAIN_W-1:0]           p_gain;

    // two shift-add multipliers shared by both passes
    wvpd_bit_mac u_mac0 (
        .clk          (clk),
        .ctrl         (ctrl0),
        .multiplicand (op0),
        .product      (prod0)
    );

    wvpd_bit_mac u_mac1 (
        .clk          (clk),
        .ctrl         (ctrl1),
        .multiplicand (op1),
        .product      (prod1)
    );

    assign p_gain   = wheel_reg ? right_p_reg : left_p_reg;
    assign out_free = !out_valid_reg || out_ready;

    // multiplier operands and control
    always_comb
    begin
        if (state_reg == S_MUL2)
        begin
            op0 = MAC_IN_W'(err_reg);
            op1 = derr_reg;
        end
        else
        begin
            op0 = MAC_IN_W'(tgt_reg);
            op1 = MAC_IN_W'(meas_reg);
        end
        ctrl0.clear    = (state_reg == S_IDLE) || (state_reg == S_ERR);
        ctrl1.clear    = ctrl0.clear;
        ctrl0.step     = (state_reg == S_MUL1) || (state_reg == S_MUL2);
        ctrl1.step     = ctrl0.step;
        ctrl0.mult_bit = (state_reg == S_MUL2) ? p_gain[cnt_reg] : inv_radius_reg[cnt_reg];
        ctrl1.mult_bit = (state_reg == S_MUL2) ? d_gain_reg[cnt_reg]
                                               : inv_radius_reg[cnt_reg];
    end

    // scaling to angular speed, round half away from zero
    always_comb
    begin
        tgt_rnd  = prod0 + (prod0[MAC_OUT_W-1] ? ANG_HALFM : ANG_HALF);
        meas_rnd = prod1 + (prod1[MAC_OUT_W-1] ? ANG_HALFM : ANG_HALF);
        des_next = tgt_rnd[ANG_W+7:8];
        cur_ang  = meas_rnd[ANG_W+7:8];
        if (cur_ang[ANG_W-1:CUR_W-1] != {(ANG_W-CUR_W+1){cur_ang[CUR_W-1]}})
        begin
            cur_next = cur_ang[ANG_W-1] ? {1'b1, {(CUR_W-1){1'b0}}}
                                        : {1'b0, {(CUR_W-1){1'b1}}};
        end
        else
        begin
            cur_next = cur_ang[CUR_W-1:0];
        end
    end

    // deadband test and clamp of the desired speed
    always_comb
    begin
        des_mag     = des_reg[ANG_W-1] ? ANG_W'(-des_reg) : des_reg;
        in_deadband = des_mag <= {{(ANG_W-LIM_W){1'b0}}, deadband_reg};
        lim_s       = $signed({{(ANG_W-LIM_W){1'b0}}, max_ang_reg});
        if (des_reg > lim_s)
        begin
            desc_next = lim_s[DES_W-1:0];
        end
        else if (des_reg < -lim_s)
        begin
            desc_next = DES_W'(-lim_s);
        end
        else
        begin
            desc_next = des_reg[DES_W-1:0];
        end
    end

    // error and change of error
    always_comb
    begin
        err_next  = ERR_W'(desc_reg) - ERR_W'(cur_reg);
        derr_next = DERR_W'(err_next) - DERR_W'(prev_err_reg[wheel_reg]);
    end

    // sum of terms, rounding, accumulator update
    always_comb
    begin
        sum_next  = SUM_W'(prod0) + (skip_reg[wheel_reg] ? SUM_W'(0) : SUM_W'(prod1));
        sum_rnd   = sum_reg + (sum_reg[SUM_W-1] ? SUM_HALFM : SUM_HALF);
        step_next = sum_rnd[SUM_W-1:16];
        nd_raw    = NDR_W'(acc_reg[wheel_reg]) + NDR_W'(step_reg);
        md_s      = $signed({{(NDR_W-DRIVE_BITS){1'b0}}, max_drive_reg});
        if (nd_raw > md_s)
        begin
            nd = md_s[ACC_W-1:0];
        end
        else if (nd_raw < -md_s)
        begin
            nd = ACC_W'(-md_s);
        end
        else
        begin
            nd = nd_raw[ACC_W-1:0];
        end
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        load_out      = 1'b0;
        commit        = 1'b0;
        wheel_id_next = wheel_reg;
        mag_next      = '0;
        dir_next      = 1'b0;
        sdrive_next   = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cnt_next   = CNT_W'(GAIN_W - 1);
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                if (!in_deadband)
                begin
                    state_next = S_ERR;
                end
                else if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_ERR:
            begin
                cnt_next   = CNT_W'(GAIN_W - 1);
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                state_next = S_RND;
            end
            S_RND:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (out_free)
                begin
                    load_out    = 1'b1;
                    commit      = 1'b1;
                    mag_next    = nd[ACC_W-1] ? DRIVE_BITS'(-nd) : nd[DRIVE_BITS-1:0];
                    dir_next    = nd[ACC_W-1] ^ wheel_reg;
                    sdrive_next = nd;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control registers and per-wheel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 2; i++)
            begin
                prev_err_reg[i] <= '0;
                skip_reg[i]     <= 1'b1;
                acc_reg[i]      <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (commit)
            begin
                prev_err_reg[wheel_reg] <= err_reg;
                skip_reg[wheel_reg]     <= 1'b0;
                acc_reg[wheel_reg]      <= nd;
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_radius_reg <= GAIN_W'(2560);
            left_p_reg     <= GAIN_W'(307);
            right_p_reg    <= GAIN_W'(256);
            d_gain_reg     <= '0;
            max_ang_reg    <= {LIM_W{1'b1}};
            max_drive_reg  <= {DRIVE_BITS{1'b1}};
            deadband_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_INV_RADIUS: inv_radius_reg <= cfg_data;
                REG_LEFT_P:     left_p_reg     <= cfg_data;
                REG_RIGHT_P:    right_p_reg    <= cfg_data;
                REG_D_GAIN:     d_gain_reg     <= cfg_data;
                REG_MAX_ANG:    max_ang_reg    <= cfg_data[LIM_W-1:0];
                REG_MAX_DRIVE:  max_drive_reg  <= cfg_data[DRIVE_BITS-1:0];
                REG_DEADBAND:   deadband_reg   <= cfg_data[LIM_W-1:0];
                default:        ;
            endcase
        end
    end

    // working payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            wheel_reg <= wheel_select;
            tgt_reg   <= target_speed;
            meas_reg  <= measured_speed;
        end
        if (state_reg == S_SCALE)
        begin
            des_reg <= des_next;
            cur_reg <= cur_next;
        end
        if (state_reg == S_CLAMP)
        begin
            desc_reg <= desc_next;
        end
        if (state_reg == S_ERR)
        begin
            err_reg  <= err_next;
            derr_reg <= derr_next;
        end
        if (state_reg == S_SUM)
        begin
            sum_reg <= sum_next;
        end
        if (state_reg == S_RND)
        begin
            step_reg <= step_next;
        end
        if (load_out)
        begin
            wheel_id_reg <= wheel_id_next;
            mag_reg      <= mag_next;
            dir_reg      <= dir_next;
            sdrive_reg   <= sdrive_next;
        end
    end

    assign in_ready        = (state_reg == S_IDLE);
    assign cfg_ready       = 1'b1;
    assign out_valid       = out_valid_reg;
    assign wheel_id        = wheel_id_reg;
    assign drive_magnitude = mag_reg;
    assign drive_direction = dir_reg;
    assign signed_drive    = sdrive_reg;

    // checks
    `WVPD_ASSERT_NEXT(a_accept_starts_scan, in_valid && in_ready, state_reg == S_MUL1,
        "accepted word did not start the scaling pass")
    `WVPD_ASSERT_NOW(a_magnitude_matches, out_valid,
        drive_magnitude == (signed_drive[DRIVE_BITS] ? DRIVE_BITS'(-signed_drive)
                                                     : signed_drive[DRIVE_BITS-1:0]),
        "drive magnitude differs from signed drive")
    `WVPD_ASSERT_NEXT(a_skip_cleared, state_reg == S_ACC && out_free,
        !skip_reg[wheel_reg] && out_valid_reg,
        "active step left derivative skip armed or dropped the result")

endmodule

>>> src/wvpd_bit_mac.sv
module wvpd_bit_mac (
    input  logic                                  clk,
    input  wvpd_pkg::mac_ctrl_t                   ctrl,
    input  logic signed [wvpd_pkg::MAC_IN_W-1:0]  multiplicand,
    output logic signed [wvpd_pkg::MAC_OUT_W-1:0] product
);
    import wvpd_pkg::*;

    logic signed [MAC_OUT_W-1:0] prod_reg;
    logic signed [MAC_OUT_W-1:0] prod_next;
    logic signed [MAC_OUT_W-1:0] addend;

    // msb-first shift and add, one multiplier bit per step
    always_comb
    begin
        addend    = ctrl.mult_bit
                  ? {{(MAC_OUT_W-MAC_IN_W){multiplicand[MAC_IN_W-1]}}, multiplicand}
                  : '0;
        prod_next = {prod_reg[MAC_OUT_W-2:0], 1'b0} + addend;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            prod_reg <= '0;
        end
        else if (ctrl.step)
        begin
            prod_reg <= prod_next;
        end
    end

    assign product = prod_reg;

endmodule
